// ----- rtl/frft_pkg.sv -----
// Shared constants, node type and control/status structs for the free-run tracker.
// Used by frft_dp, frft_ctrl, free_run_first_fit_tracker and the bench files.
package frft_pkg;

    localparam int POSITIONS = 1024;
    localparam int LOG_POS   = 10;
    localparam int NODE_W    = LOG_POS + 1;
    localparam int ADDR_W    = LOG_POS + 1;
    localparam int DEPTH     = 2 * POSITIONS;
    localparam int NODE_BITS = 3 * NODE_W;
    localparam int CMD_W     = 2;
    localparam int VALUE_W   = 10;

    localparam logic [CMD_W-1:0] CMD_OCCUPY = 2'd0;
    localparam logic [CMD_W-1:0] CMD_FREE   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_QUERY  = 2'd2;

    typedef struct packed {
        logic [NODE_W-1:0] best;
        logic [NODE_W-1:0] pre;
        logic [NODE_W-1:0] suf;
    } t_node;

    typedef struct packed {
        logic init_wr;
        logic load;
        logic leaf_wr;
        logic root_rd;
        logic child_rd;
        logic join_wr;
        logic q_step;
        logic miss;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic init_last;
        logic mark_ok;
        logic is_query;
        logic k_zero;
        logic at_root;
        logic root_fit;
        logic left_fit;
        logic mid_fit;
        logic child_leaf;
        logic out_free;
    } t_stat;

    // Merge two sibling nodes whose sizes are both half.
    function automatic t_node join_nodes(t_node a, t_node b, logic [NODE_W-1:0] half);
        t_node z;
        logic [NODE_W-1:0] m;
        logic [NODE_W-1:0] mid;
        m      = (a.best > b.best) ? a.best : b.best;
        mid    = a.suf + b.pre;
        z.best = (mid > m) ? mid : m;
        z.pre  = a.pre + ((a.pre == half) ? b.pre : '0);
        z.suf  = b.suf + ((b.suf == half) ? a.suf : '0);
        return z;
    endfunction

endpackage

// ----- rtl/frft_ram.sv -----
// Generic RAM: one write port, two read ports, registered read data.
// Standalone; no package dependency.
module frft_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_a,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_b,
    output logic [WIDTH-1:0]         o_rdata_a,
    output logic [WIDTH-1:0]         o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata_a <= r_mem[i_raddr_a];
        o_rdata_b <= r_mem[i_raddr_b];
    end

endmodule

// ----- rtl/frft_dp.sv -----
// Datapath: node RAM, tree walk registers, join logic and the result register.
// Depends on frft_pkg and frft_ram.
module frft_dp (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  frft_pkg::t_cmd                i_cmd_ctl,
    input  logic [frft_pkg::CMD_W-1:0]    i_cmd,
    input  logic [frft_pkg::VALUE_W-1:0]  i_value,
    input  logic                          i_ready,
    output frft_pkg::t_stat               o_stat,
    output logic                          o_valid,
    output logic [frft_pkg::VALUE_W-1:0]  o_window_start,
    output logic                          o_found
);

    logic [frft_pkg::ADDR_W-1:0]  r_node, n_node;
    logic [frft_pkg::NODE_W-1:0]  r_size, n_size;
    logic [frft_pkg::NODE_W-1:0]  r_base, n_base;
    logic [frft_pkg::NODE_W-1:0]  r_ans, n_ans;
    logic                         r_hit, n_hit;
    logic [frft_pkg::CMD_W-1:0]   r_cmd;
    logic [frft_pkg::VALUE_W-1:0] r_value;
    logic                         r_out_valid;
    logic [frft_pkg::VALUE_W-1:0] r_out_start;
    logic                         r_out_found;

    logic [frft_pkg::NODE_W-1:0]    half;
    logic [frft_pkg::ADDR_W-1:0]    node_next;
    logic                           node_pow2;
    logic                           next_pow2;
    frft_pkg::t_node                init_node;
    frft_pkg::t_node                leaf_node;
    frft_pkg::t_node                rd_a, rd_b;
    logic [frft_pkg::NODE_BITS-1:0] rdata_a, rdata_b;
    logic                           we;
    logic [frft_pkg::ADDR_W-1:0]    waddr, raddr_a, raddr_b;
    frft_pkg::t_node                wdata;
    logic                           is_free;

    assign half      = r_size >> 1;
    assign node_next = r_node + 1'b1;
    assign node_pow2 = (r_node & (r_node - 1'b1)) == '0;
    assign next_pow2 = (node_next & (node_next - 1'b1)) == '0;
    assign rd_a      = frft_pkg::t_node'(rdata_a);
    assign rd_b      = frft_pkg::t_node'(rdata_b);
    assign is_free   = (r_cmd == frft_pkg::CMD_FREE);

    // Reset image: the leftmost node of each level holds leaf 0, which is never free.
    always_comb begin
        if (node_pow2) begin
            init_node.best = r_size - 1'b1;
            init_node.pre  = '0;
            init_node.suf  = r_size - 1'b1;
        end else begin
            init_node.best = r_size;
            init_node.pre  = r_size;
            init_node.suf  = r_size;
        end
        leaf_node.best = frft_pkg::NODE_W'(is_free);
        leaf_node.pre  = frft_pkg::NODE_W'(is_free);
        leaf_node.suf  = frft_pkg::NODE_W'(is_free);
    end

    always_comb begin
        we      = 1'b0;
        waddr   = r_node;
        wdata   = init_node;
        raddr_a = {r_node[frft_pkg::ADDR_W-2:0], 1'b0};
        raddr_b = {r_node[frft_pkg::ADDR_W-2:0], 1'b1};
        if (i_cmd_ctl.init_wr) begin
            we = 1'b1;
        end else if (i_cmd_ctl.leaf_wr) begin
            we    = 1'b1;
            waddr = frft_pkg::ADDR_W'(frft_pkg::POSITIONS) + frft_pkg::ADDR_W'(r_value);
            wdata = leaf_node;
        end else if (i_cmd_ctl.join_wr) begin
            we    = 1'b1;
            wdata = frft_pkg::join_nodes(rd_a, rd_b, half);
        end
        if (i_cmd_ctl.root_rd) begin
            raddr_a = frft_pkg::ADDR_W'(1);
        end
    end

    frft_ram #(
        .WIDTH (frft_pkg::NODE_BITS),
        .DEPTH (frft_pkg::DEPTH)
    ) u_ram (
        .i_clk     (i_clk),
        .i_we      (we),
        .i_waddr   (waddr),
        .i_wdata   (wdata),
        .i_raddr_a (raddr_a),
        .i_raddr_b (raddr_b),
        .o_rdata_a (rdata_a),
        .o_rdata_b (rdata_b)
    );

    always_comb begin
        n_node = r_node;
        n_size = r_size;
        n_base = r_base;
        n_ans  = r_ans;
        n_hit  = r_hit;
        if (i_cmd_ctl.init_wr) begin
            n_node = node_next;
            if (next_pow2 && !o_stat.init_last) begin
                n_size = r_size >> 1;
            end
        end else if (i_cmd_ctl.leaf_wr) begin
            n_node = (frft_pkg::ADDR_W'(frft_pkg::POSITIONS) +
                      frft_pkg::ADDR_W'(r_value)) >> 1;
            n_size = frft_pkg::NODE_W'(2);
        end else if (i_cmd_ctl.join_wr) begin
            if (!o_stat.at_root) begin
                n_node = r_node >> 1;
                n_size = r_size << 1;
            end
        end else if (i_cmd_ctl.root_rd) begin
            n_node = frft_pkg::ADDR_W'(1);
            n_size = frft_pkg::NODE_W'(frft_pkg::POSITIONS);
            n_base = '0;
        end else if (i_cmd_ctl.miss) begin
            n_hit = 1'b0;
            n_ans = '0;
        end else if (i_cmd_ctl.q_step) begin
            if (o_stat.left_fit) begin
                if (o_stat.child_leaf) begin
                    n_hit = 1'b1;
                    n_ans = r_base;
                end else begin
                    n_node = r_node << 1;
                    n_size = half;
                end
            end else if (o_stat.mid_fit) begin
                // window straddles the midpoint: it starts at the left child's free suffix
                n_hit = 1'b1;
                n_ans = r_base + half - rd_a.suf;
            end else if (o_stat.child_leaf) begin
                n_hit = 1'b1;
                n_ans = r_base + half;
            end else begin
                n_node = {r_node[frft_pkg::ADDR_W-2:0], 1'b1};
                n_base = r_base + half;
                n_size = half;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_node      <= frft_pkg::ADDR_W'(1);
            r_size      <= frft_pkg::NODE_W'(frft_pkg::POSITIONS);
            r_base      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_node <= n_node;
            r_size <= n_size;
            r_base <= n_base;
            if (i_cmd_ctl.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_ans <= n_ans;
        r_hit <= n_hit;
        if (i_cmd_ctl.load) begin
            r_cmd   <= i_cmd;
            r_value <= i_value;
        end
        if (i_cmd_ctl.out_load) begin
            r_out_start <= r_ans[frft_pkg::VALUE_W-1:0];
            r_out_found <= r_hit;
        end
    end

    always_comb begin
        o_stat.init_last  = (r_node == frft_pkg::ADDR_W'(frft_pkg::DEPTH - 1));
        o_stat.mark_ok    = ((r_cmd == frft_pkg::CMD_OCCUPY) || (r_cmd == frft_pkg::CMD_FREE))
                            && (r_value != '0)
                            && (32'(r_value) < 32'(frft_pkg::POSITIONS));
        o_stat.is_query   = (r_cmd == frft_pkg::CMD_QUERY);
        o_stat.k_zero     = (r_value == '0);
        o_stat.at_root    = (r_node == frft_pkg::ADDR_W'(1));
        o_stat.root_fit   = 32'(rd_a.best) >= 32'(r_value);
        o_stat.left_fit   = 32'(rd_a.best) >= 32'(r_value);
        o_stat.mid_fit    = (32'(rd_a.suf) + 32'(rd_b.pre)) >= 32'(r_value);
        o_stat.child_leaf = (r_size == frft_pkg::NODE_W'(2));
        o_stat.out_free   = !r_out_valid || i_ready;
    end

    assign o_valid        = r_out_valid;
    assign o_window_start = r_out_start;
    assign o_found        = r_out_found;

`ifndef SYNTHESIS
    a_size_pow2: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot(r_size))
        else $error("node size is not a power of two");

    a_hit_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd_ctl.out_load && r_hit |-> (r_ans != '0)
            && (32'(r_ans) < 32'(frft_pkg::POSITIONS)))
        else $error("window start outside the tracked positions");

    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd_ctl.out_load && !r_hit |-> (r_ans == '0))
        else $error("miss carries a nonzero start");
`endif

endmodule

// ----- rtl/frft_ctrl.sv -----
// Controller: sequences the tree build, leaf updates and first-fit descent.
// Depends on frft_pkg.
module frft_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  frft_pkg::t_stat i_stat,
    output logic            o_ready,
    output frft_pkg::t_cmd  o_cmd_ctl
);

    localparam logic [3:0] S_INIT   = 4'd0;
    localparam logic [3:0] S_IDLE   = 4'd1;
    localparam logic [3:0] S_DISP   = 4'd2;
    localparam logic [3:0] S_UP_RD  = 4'd3;
    localparam logic [3:0] S_UP_WR  = 4'd4;
    localparam logic [3:0] S_Q_ROOT = 4'd5;
    localparam logic [3:0] S_Q_RD   = 4'd6;
    localparam logic [3:0] S_Q_STEP = 4'd7;
    localparam logic [3:0] S_Q_OUT  = 4'd8;

    logic [3:0] r_state, n_state;

    assign o_ready = (r_state == S_IDLE);

    always_comb begin
        n_state   = r_state;
        o_cmd_ctl = '0;
        case (r_state)
            S_INIT: begin
                o_cmd_ctl.init_wr = 1'b1;
                if (i_stat.init_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd_ctl.load = 1'b1;
                    n_state        = S_DISP;
                end
            end
            S_DISP: begin
                if (i_stat.mark_ok) begin
                    o_cmd_ctl.leaf_wr = 1'b1;
                    n_state           = S_UP_RD;
                end else if (i_stat.is_query && i_stat.k_zero) begin
                    o_cmd_ctl.miss = 1'b1;
                    n_state        = S_Q_OUT;
                end else if (i_stat.is_query) begin
                    o_cmd_ctl.root_rd = 1'b1;
                    n_state           = S_Q_ROOT;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_UP_RD: begin
                o_cmd_ctl.child_rd = 1'b1;
                n_state            = S_UP_WR;
            end
            S_UP_WR: begin
                o_cmd_ctl.join_wr = 1'b1;
                n_state           = i_stat.at_root ? S_IDLE : S_UP_RD;
            end
            S_Q_ROOT: begin
                if (i_stat.root_fit) begin
                    o_cmd_ctl.child_rd = 1'b1;
                    n_state            = S_Q_STEP;
                end else begin
                    o_cmd_ctl.miss = 1'b1;
                    n_state        = S_Q_OUT;
                end
            end
            S_Q_RD: begin
                o_cmd_ctl.child_rd = 1'b1;
                n_state            = S_Q_STEP;
            end
            S_Q_STEP: begin
                o_cmd_ctl.q_step = 1'b1;
                if (i_stat.child_leaf || (i_stat.mid_fit && !i_stat.left_fit)) begin
                    n_state = S_Q_OUT;
                end else begin
                    n_state = S_Q_RD;
                end
            end
            S_Q_OUT: begin
                // hold the answer until the result register frees up
                if (i_stat.out_free) begin
                    o_cmd_ctl.out_load = 1'b1;
                    n_state            = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ----- rtl/free_run_first_fit_tracker.sv -----
// Free-run first-fit tracker: segment tree of free runs over positions 1..POSITIONS-1.
// Top level; depends on frft_pkg, frft_ctrl and frft_dp.
//
// Input channel (i_valid / o_ready): i_cmd 0 marks i_value occupied, 1 marks it free,
// 2 asks for the leftmost window of i_value consecutive free positions. Code 3, and
// marks of position 0 or beyond range, are dropped.
// Output channel (o_valid / i_ready): one transfer per query, o_found with
// o_window_start (zero when nothing fits). Marks produce no transfer.
// Items are handled one at a time. A mark writes its leaf, then makes one
// read/join/write pass per tree level through the node RAM, up to the root.
// A nonzero query goes through dispatch and a root read, then a child read and a
// step per level of descent, the root read state issuing the first child read;
// a zero query misses at dispatch. Each ends by loading the result register.
// After reset the block builds the tree image, one node per cycle, over nodes 1 to
// 2*POSITIONS-1 (2047), with o_ready low; then positions 1..POSITIONS-1 are free.
// The result sits in an output register: a stalled receiver does not block the next
// item, but a second query holds before its final cycle until the first is taken.
module free_run_first_fit_tracker (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic [frft_pkg::CMD_W-1:0]   i_cmd,
    input  logic [frft_pkg::VALUE_W-1:0] i_value,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic [frft_pkg::VALUE_W-1:0] o_window_start,
    output logic                         o_found
);

    frft_pkg::t_cmd  cmd_ctl;
    frft_pkg::t_stat stat;

    frft_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .i_stat    (stat),
        .o_ready   (o_ready),
        .o_cmd_ctl (cmd_ctl)
    );

    frft_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd_ctl      (cmd_ctl),
        .i_cmd          (i_cmd),
        .i_value        (i_value),
        .i_ready        (i_ready),
        .o_stat         (stat),
        .o_valid        (o_valid),
        .o_window_start (o_window_start),
        .o_found        (o_found)
    );

endmodule

// ----- bench/free_run_first_fit_checker.sv -----
// Checker for the free-run first-fit tracker: watches both channels, models occupancy
// and compares each query answer with the leftmost free window. Depends on frft_pkg.
module free_run_first_fit_checker (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    input  logic                         i_in_ready,
    input  logic [frft_pkg::CMD_W-1:0]   i_cmd,
    input  logic [frft_pkg::VALUE_W-1:0] i_value,
    input  logic                         i_out_valid,
    input  logic                         i_ready,
    input  logic [frft_pkg::VALUE_W-1:0] i_window_start,
    input  logic                         i_found,
    output int                           o_errors,
    output int                           o_pending
);

    typedef struct {
        logic [frft_pkg::VALUE_W-1:0] start;
        logic                         found;
    } t_answer;

    logic    occupied [frft_pkg::POSITIONS];
    t_answer answer_q [$];

    // Scan from the left for the first run of k free positions.
    function automatic t_answer first_fit(logic [frft_pkg::VALUE_W-1:0] k);
        t_answer a;
        int run;
        a.start = '0;
        a.found = 1'b0;
        run = 0;
        if (k != 0) begin
            for (int p = 1; p < frft_pkg::POSITIONS; p++) begin
                run = occupied[p] ? 0 : run + 1;
                if (run == k) begin
                    a.start = frft_pkg::VALUE_W'(p - k + 1);
                    a.found = 1'b1;
                    break;
                end
            end
        end
        return a;
    endfunction

    assign o_pending = answer_q.size();

    always @(posedge i_clk) begin
        t_answer e;
        if (!i_rst_n) begin
            foreach (occupied[p]) occupied[p] = 1'b0;
            answer_q.delete();
            o_errors <= 0;
        end else begin
            if (i_out_valid && i_ready) begin
                if (answer_q.size() == 0) begin
                    $display("%0t: unexpected result start=%0d found=%0b", $time,
                             i_window_start, i_found);
                    o_errors <= o_errors + 1;
                end else begin
                    e = answer_q.pop_front();
                    if (e.found !== i_found || e.start !== i_window_start) begin
                        $display("%0t: expected start=%0d found=%0b, got start=%0d found=%0b",
                                 $time, e.start, e.found, i_window_start, i_found);
                        o_errors <= o_errors + 1;
                    end
                end
            end
            if (i_valid && i_in_ready) begin
                case (i_cmd)
                    frft_pkg::CMD_OCCUPY, frft_pkg::CMD_FREE: begin
                        if (i_value != 0 && i_value < frft_pkg::POSITIONS)
                            occupied[i_value] = (i_cmd == frft_pkg::CMD_OCCUPY);
                    end
                    frft_pkg::CMD_QUERY: answer_q.push_back(first_fit(i_value));
                    default: ;
                endcase
            end
        end
    end
endmodule

// ----- bench/free_run_first_fit_tracker_test.sv -----
// Testbench top for free_run_first_fit_tracker: drives marks and queries with random
// gaps and stalls; depends on frft_pkg, the block and free_run_first_fit_checker.
module free_run_first_fit_tracker_test;

    localparam int WATCHDOG = 20000;
    localparam logic [frft_pkg::CMD_W-1:0] CMD_UNUSED = 2'd3;

    logic                         i_clk;
    logic                         i_rst_n;
    logic                         i_valid;
    logic                         o_ready;
    logic [frft_pkg::CMD_W-1:0]   i_cmd;
    logic [frft_pkg::VALUE_W-1:0] i_value;
    logic                         o_valid;
    logic                         i_ready;
    logic [frft_pkg::VALUE_W-1:0] o_window_start;
    logic                         o_found;
    int                           errors;
    int                           pending;
    int                           send_idle_pct;
    int                           recv_stall_pct;
    int                           idle_count;
    bit                           hold_off;

    free_run_first_fit_tracker u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_ready(o_ready),
        .i_cmd(i_cmd), .i_value(i_value), .o_valid(o_valid), .i_ready(i_ready),
        .o_window_start(o_window_start), .o_found(o_found)
    );

    free_run_first_fit_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .i_in_ready(o_ready),
        .i_cmd(i_cmd), .i_value(i_value), .i_out_valid(o_valid), .i_ready(i_ready),
        .i_window_start(o_window_start), .i_found(o_found),
        .o_errors(errors), .o_pending(pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Receiver: random stalls, or a long hold-off when asked.
    always @(negedge i_clk) begin
        if (!i_rst_n || hold_off)
            i_ready <= 1'b0;
        else
            i_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Watchdog: count cycles with no transfer on either channel.
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready) || !i_rst_n)
            idle_count <= 0;
        else
            idle_count <= idle_count + 1;
        if (idle_count >= WATCHDOG) begin
            $display("free_run_first_fit_tracker test failed");
            $finish;
        end
    end

    // Offer one item and hold it until the transfer; valid stays up for the next item.
    task automatic send_item(logic [frft_pkg::CMD_W-1:0]   cmd,
                             logic [frft_pkg::VALUE_W-1:0] value);
        if ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
            while ($urandom_range(99) < send_idle_pct) @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_cmd   <= cmd;
        i_value <= value;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // Random mix of queries, marks (mostly low-end, so queries see a fragmented map) and unused codes.
    task automatic send_random;
        int r;
        logic [frft_pkg::VALUE_W-1:0] v;
        r = $urandom_range(99);
        if (r < 3)
            send_item(CMD_UNUSED, frft_pkg::VALUE_W'($urandom));
        else if (r < 50) begin
            v = ($urandom_range(3) == 0) ? frft_pkg::VALUE_W'($urandom)
                                         : frft_pkg::VALUE_W'($urandom_range(1, 80));
            send_item(($urandom_range(2) == 0) ? frft_pkg::CMD_FREE : frft_pkg::CMD_OCCUPY, v);
        end else begin
            case ($urandom_range(3))
                0: v = frft_pkg::VALUE_W'($urandom);
                1: v = frft_pkg::VALUE_W'($urandom_range(0, 40));
                default: v = frft_pkg::VALUE_W'($urandom_range(1, 12));
            endcase
            send_item(frft_pkg::CMD_QUERY, v);
        end
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_cmd = frft_pkg::CMD_OCCUPY;
        i_value = '0;
        hold_off = 1'b0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        repeat (4) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: empty map extremes, unused code, a mark of position 0, edge and middle marks.
        send_item(frft_pkg::CMD_QUERY, 10'd1);
        send_item(frft_pkg::CMD_QUERY, 10'd1023);
        send_item(frft_pkg::CMD_QUERY, 10'd0);
        send_item(CMD_UNUSED, 10'd5);
        send_item(frft_pkg::CMD_OCCUPY, 10'd0);
        send_item(frft_pkg::CMD_QUERY, 10'd1023);
        send_item(frft_pkg::CMD_OCCUPY, 10'd1023);
        send_item(frft_pkg::CMD_QUERY, 10'd1023);
        send_item(frft_pkg::CMD_QUERY, 10'd1022);
        send_item(frft_pkg::CMD_OCCUPY, 10'd1);
        send_item(frft_pkg::CMD_QUERY, 10'd1022);
        send_item(frft_pkg::CMD_QUERY, 10'd1021);
        send_item(frft_pkg::CMD_OCCUPY, 10'd512);
        send_item(frft_pkg::CMD_QUERY, 10'd511);
        send_item(frft_pkg::CMD_QUERY, 10'd510);
        send_item(frft_pkg::CMD_QUERY, 10'd3);
        send_item(frft_pkg::CMD_FREE, 10'd1);
        send_item(frft_pkg::CMD_FREE, 10'd1023);
        send_item(frft_pkg::CMD_FREE, 10'd512);
        send_item(frft_pkg::CMD_QUERY, 10'd1023);
        send_item(frft_pkg::CMD_FREE, 10'h3ff);
        send_item(frft_pkg::CMD_QUERY, 10'h2aa);
        send_item(frft_pkg::CMD_QUERY, 10'h155);

        // Long receiver hold-off while queries keep coming.
        hold_off = 1'b1;
        fork
            begin
                repeat (300) @(negedge i_clk);
                hold_off = 1'b0;
            end
            repeat (4) send_item(frft_pkg::CMD_QUERY,
                                 frft_pkg::VALUE_W'($urandom_range(1, 20)));
        join

        for (int phase = 0; phase < 4; phase++) begin
            send_idle_pct  = (phase == 1) ? 52 : (phase == 3) ? 34 : 0;
            recv_stall_pct = (phase == 2) ? 52 : (phase == 3) ? 34 : 0;
            repeat (295) send_random();
        end
        i_valid <= 1'b0;

        while (pending != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
        if (errors == 0)
            $display("free_run_first_fit_tracker test passed");
        else
            $display("free_run_first_fit_tracker test failed");
        $finish;
    end
endmodule

// ----- filelist.f -----
rtl/frft_pkg.sv
rtl/frft_ram.sv
rtl/frft_dp.sv
rtl/frft_ctrl.sv
rtl/free_run_first_fit_tracker.sv
bench/free_run_first_fit_checker.sv
bench/free_run_first_fit_tracker_test.sv
